// ===== rtl/core/sprite_quad_vertex_generator_core_macros.svh =====
// assertion helpers
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_CORE_MACROS_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_CORE_MACROS_SVH
`define SQV_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define SQV_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`endif

// ===== rtl/core/sqv_pkg.sv =====
package sqv_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ATAN_ENTRIES        = 24;
    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

    typedef struct packed {
        logic        cmd;
        logic signed [31:0] dest_x, dest_y, dest_w, dest_h;
        logic signed [31:0] uv_x, uv_y, uv_w, uv_h;
        logic [15:0] tex_handle;
        logic [31:0] rgba;
        logic signed [15:0] angle;
    } t_sprite;

    typedef struct packed {
        logic [1:0]  corner;
        logic signed [31:0] pos_x, pos_y, tex_u, tex_v;
        logic [31:0] vertex_color;
        logic [15:0] vertex_texture;
        logic        last;
    } t_vertex;

    function automatic logic signed [33:0] atan_q30(input int i);
        case (i)
            0: atan_q30 = 34'sd843314856;   1: atan_q30 = 34'sd497837829;
            2: atan_q30 = 34'sd263043836;   3: atan_q30 = 34'sd133525158;
            4: atan_q30 = 34'sd67021686;    5: atan_q30 = 34'sd33543515;
            6: atan_q30 = 34'sd16775850;    7: atan_q30 = 34'sd8388437;
            8: atan_q30 = 34'sd4194282;     9: atan_q30 = 34'sd2097149;
            10: atan_q30 = 34'sd1048575;    11: atan_q30 = 34'sd524287;
            12: atan_q30 = 34'sd262143;     13: atan_q30 = 34'sd131071;
            14: atan_q30 = 34'sd65535;      15: atan_q30 = 34'sd32767;
            16: atan_q30 = 34'sd16383;      17: atan_q30 = 34'sd8191;
            18: atan_q30 = 34'sd4095;       19: atan_q30 = 34'sd2047;
            20: atan_q30 = 34'sd1023;       21: atan_q30 = 34'sd511;
            22: atan_q30 = 34'sd255;        23: atan_q30 = 34'sd127;
            default: atan_q30 = '0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
        else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction
endpackage

// ===== rtl/core/sqv_if.sv =====
interface sqv_sprite_if import sqv_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sprite data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sqv_vertex_if import sqv_pkg::*; ();
    logic    valid;
    logic    ready;
    t_vertex data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sprite_quad_vertex_generator_core.sv =====
// Sprite quad vertex generator.
// i_sprite: one sprite per transaction (valid/ready). o_vertex: four vertex
// transactions per sprite, corners top-left, bottom-left, bottom-right,
// top-right, last set on the fourth.
// Data passes through the sine/cosine pipeline, then the corner stages
// (hold, multiply, sum, saturate). One vertex per cycle while o_vertex is
// ready; the hold register takes a new sprite once it has issued all four
// corners; the CORDIC pipeline takes a sprite each cycle unless stalled.
// Reset clears all valid bits; payload is not reset.
// A stall on o_vertex holds the corner stages and, once the holding
// register is full, the CORDIC pipeline and i_sprite ready; nothing is
// lost or repeated.
`include "sprite_quad_vertex_generator_core_macros.svh"
module sprite_quad_vertex_generator_core import sqv_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    sqv_sprite_if.sink   i_sprite,
    sqv_vertex_if.source o_vertex
);
    logic    c_valid, c_ready, en;
    t_sprite c_item;
    logic signed [33:0] c_cos, c_sin;

    assign en = !c_valid || c_ready;
    assign i_sprite.ready = en;

    sqv_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_sprite.valid), .i_item(i_sprite.data),
        .o_valid(c_valid), .o_item(c_item), .o_cos(c_cos), .o_sin(c_sin)
    );

    sqv_corner u_corner (
        .i_clk, .i_rst_n, .i_valid(c_valid), .i_item(c_item), .i_cos(c_cos),
        .i_sin(c_sin), .o_ready(c_ready), .o_valid(o_vertex.valid),
        .i_ready(o_vertex.ready), .o_vert(o_vertex.data)
    );

    `SQV_ASSERT_IMP(a_last_corner, i_clk, i_rst_n, o_vertex.valid,
        o_vertex.data.last == (o_vertex.data.corner == 2'd3))
    `SQV_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_vertex.valid && !o_vertex.ready,
        o_vertex.valid && $stable(o_vertex.data.corner))
endmodule

// ===== rtl/core/sqv_cordic.sv =====
module sqv_cordic import sqv_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_sprite i_item,
    output logic    o_valid,
    output t_sprite o_item,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    logic              r_v [N+1];
    t_sprite           r_it [N+1];
    logic signed [33:0] r_x [N+1], r_y [N+1], r_z [N+1];
    logic              r_f [N+1];
    logic signed [33:0] n_z0;
    logic              n_f0;

    always_comb begin
        n_z0 = 34'(i_item.angle) <<< (30 - ANGLE_FRAC_BITS);
        n_f0 = 1'b0;
        if (n_z0 > Q30_HALF_PI) begin
            n_z0 = n_z0 - Q30_PI; n_f0 = 1'b1;
        end else if (n_z0 < -Q30_HALF_PI) begin
            n_z0 = n_z0 + Q30_PI; n_f0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= N; k++) r_v[k] <= r_v[k-1];
        end
        if (i_en) begin
            r_it[0] <= i_item; r_x[0] <= Q30_GAIN; r_y[0] <= '0;
            r_z[0] <= n_z0; r_f[0] <= n_f0;
            for (int k = 1; k <= N; k++) begin
                r_it[k] <= r_it[k-1]; r_f[k] <= r_f[k-1];
                if (!r_z[k-1][33]) begin
                    r_x[k] <= r_x[k-1] - (r_y[k-1] >>> (k-1));
                    r_y[k] <= r_y[k-1] + (r_x[k-1] >>> (k-1));
                    r_z[k] <= r_z[k-1] - atan_q30(k-1);
                end else begin
                    r_x[k] <= r_x[k-1] + (r_y[k-1] >>> (k-1));
                    r_y[k] <= r_y[k-1] - (r_x[k-1] >>> (k-1));
                    r_z[k] <= r_z[k-1] + atan_q30(k-1);
                end
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_item  = r_it[N];
    assign o_cos   = r_f[N] ? -r_x[N] : r_x[N];
    assign o_sin   = r_f[N] ? -r_y[N] : r_y[N];
endmodule

// ===== rtl/core/sqv_corner.sv =====
module sqv_corner import sqv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sprite i_item,
    input  logic signed [33:0] i_cos,
    input  logic signed [33:0] i_sin,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_vertex o_vert
);
    // hold sprite, expand to four corners over stages
    logic               r_hv;
    t_sprite            r_h;
    logic signed [33:0] r_c, r_s;
    logic [1:0]         r_k;
    logic               r_v1, r_v2, r_v3;
    t_vertex            r_b1, r_b2, r_b3;
    t_vertex            n_b3;
    logic               r_rot1, r_rot2;
    logic signed [65:0] r_wc, r_ws, r_hc, r_hs;
    logic signed [65:0] r_rx, r_ry;
    logic signed [31:0] r_dx1, r_dy1, r_dx2, r_dy2;
    logic signed [31:0] r_w1, r_h1;
    logic               r_rt1, r_tp1;
    logic               en, take, rt, tp;

    assign en = !r_v3 || i_ready;
    assign take = r_hv && en;
    assign o_ready = !r_hv || (take && r_k == 2'd3);
    assign rt = r_k[1];
    assign tp = (r_k == 2'd0) || (r_k == 2'd3);

    always_comb begin
        n_b3 = r_b2;
        if (r_rot2) begin
            n_b3.pos_x = sat32(66'(r_dx2) + (r_rx >>> 31));
            n_b3.pos_y = sat32(66'(r_dy2) + (r_ry >>> 31));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0; r_k <= '0; r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_hv <= 1'b1;
            end else if (take && r_k == 2'd3) begin
                r_hv <= 1'b0;
            end
            if (take) r_k <= r_k + 2'd1;
            if (en) begin
                r_v1 <= r_hv; r_v2 <= r_v1; r_v3 <= r_v2;
            end
        end
        if (i_valid && o_ready) begin
            r_h <= i_item; r_c <= i_cos; r_s <= i_sin;
        end
        if (en) begin
            r_b1.corner <= r_k;
            r_b1.pos_x <= rt ? sat32(66'(r_h.dest_x) + 66'(r_h.dest_w)) : r_h.dest_x;
            r_b1.pos_y <= tp ? sat32(66'(r_h.dest_y) + 66'(r_h.dest_h)) : r_h.dest_y;
            r_b1.tex_u <= rt ? sat32(66'(r_h.uv_x) + 66'(r_h.uv_w)) : r_h.uv_x;
            r_b1.tex_v <= tp ? sat32(66'(r_h.uv_y) + 66'(r_h.uv_h)) : r_h.uv_y;
            r_b1.vertex_color <= r_h.rgba;
            r_b1.vertex_texture <= r_h.tex_handle;
            r_b1.last <= (r_k == 2'd3);
            r_rot1 <= r_h.cmd;
            r_rt1 <= rt; r_tp1 <= tp;
            r_dx1 <= r_h.dest_x; r_dy1 <= r_h.dest_y;
            r_w1 <= r_h.dest_w; r_h1 <= r_h.dest_h;
            r_wc <= 66'(r_h.dest_w) * 66'(r_c);
            r_ws <= 66'(r_h.dest_w) * 66'(r_s);
            r_hc <= 66'(r_h.dest_h) * 66'(r_c);
            r_hs <= 66'(r_h.dest_h) * 66'(r_s);
            r_b2 <= r_b1; r_rot2 <= r_rot1; r_dx2 <= r_dx1; r_dy2 <= r_dy1;
            r_rx <= (r_rt1 ? r_wc : -r_wc) - (r_tp1 ? r_hs : -r_hs)
                    + (66'(r_w1) <<< 30) + (66'(1) <<< 30);
            r_ry <= (r_rt1 ? r_ws : -r_ws) + (r_tp1 ? r_hc : -r_hc)
                    + (66'(r_h1) <<< 30) + (66'(1) <<< 30);
            r_b3 <= n_b3;
        end
    end

    assign o_valid = r_v3;
    assign o_vert  = r_b3;
endmodule

// ===== tb/sprite_quad_vertex_generator_core_tb.sv =====
`timescale 1ns / 1ps
module sprite_quad_vertex_generator_core_tb;
    import sqv_pkg::*;

    localparam int ANGLE_FRAC = 13;
    localparam int STAGES     = 16;
    localparam int LATENCY    = STAGES + 1 + 4 + 8;
    localparam int N_RANDOM   = 260;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;
    localparam logic CMD_AXIS    = 1'b0;
    localparam logic CMD_ROTATED = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sqv_sprite_if sprite_ch ();
    sqv_vertex_if vertex_ch ();

    sprite_quad_vertex_generator_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sprite (sprite_ch.sink),
        .o_vertex (vertex_ch.source)
    );

    always #6 i_clk = ~i_clk;

    t_sprite pending_sprites[$];
    t_vertex expected_vertices[$];
    int  errors = 0;
    int  cycles = 0;
    int  vertices_seen = 0;
    int  sprites_sent = 0;
    int  rotated_sent = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  quiet = 1'b0;
    bit  hold_send = 1'b0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint arctan_step(int i);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158,
            67021686, 33543515, 16775850, 8388437, 4194282, 2097149,
            1048575, 524287, 262143, 131071, 65535, 32767, 16383, 8191,
            4095, 2047, 1023, 511, 255, 127};
        return tbl[i];
    endfunction

    task automatic sine_cosine(input logic signed [15:0] ang,
                               output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * (longint'(1) << (30 - ANGLE_FRAC));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic predict_quad(input t_sprite sp);
        longint c, s, w, h, ox2, oy2, rx, ry, px, py;
        longint half;
        bit right, top;
        t_vertex v;
        half = longint'(1) << 30;
        c = 0;
        s = 0;
        w = longint'(sp.dest_w);
        h = longint'(sp.dest_h);
        if (sp.cmd == CMD_ROTATED) sine_cosine(sp.angle, c, s);
        for (int k = 0; k < 4; k++) begin
            right = (k == CORNER_BR || k == CORNER_TR);
            top   = (k == CORNER_TL || k == CORNER_TR);
            if (sp.cmd == CMD_ROTATED) begin
                ox2 = right ? w : -w;
                oy2 = top ? h : -h;
                rx = ox2 * c - oy2 * s + w * half + half;
                ry = ox2 * s + oy2 * c + h * half + half;
                px = longint'(sp.dest_x) + floor_shift(rx, 31);
                py = longint'(sp.dest_y) + floor_shift(ry, 31);
            end else begin
                px = longint'(sp.dest_x) + (right ? w : 0);
                py = longint'(sp.dest_y) + (top ? h : 0);
            end
            v.corner = k[1:0];
            v.pos_x = clamp32(px);
            v.pos_y = clamp32(py);
            v.tex_u = clamp32(longint'(sp.uv_x) + (right ? longint'(sp.uv_w) : 0));
            v.tex_v = clamp32(longint'(sp.uv_y) + (top ? longint'(sp.uv_h) : 0));
            v.vertex_color = sp.rgba;
            v.vertex_texture = sp.tex_handle;
            v.last = (k == CORNER_TR);
            expected_vertices.push_back(v);
        end
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h01ffffff) - 32'h01000000;
        endcase
    endfunction

    function automatic t_sprite random_sprite();
        t_sprite sp;
        sp.cmd = 1'($urandom_range(0, 1));
        sp.dest_x = pick_coord();
        sp.dest_y = pick_coord();
        sp.dest_w = pick_coord();
        sp.dest_h = pick_coord();
        sp.uv_x = pick_coord();
        sp.uv_y = pick_coord();
        sp.uv_w = pick_coord();
        sp.uv_h = pick_coord();
        sp.tex_handle = 16'($urandom);
        sp.rgba = $urandom;
        sp.angle = 16'($urandom);
        return sp;
    endfunction

    function automatic t_sprite plain_sprite(logic cmd, logic [15:0] ang);
        t_sprite sp;
        sp = '0;
        sp.cmd = cmd;
        sp.dest_x = 32'sh0010_0000;
        sp.dest_y = 32'sh0020_0000;
        sp.dest_w = 32'sh0004_0000;
        sp.dest_h = 32'sh0002_8000;
        sp.uv_w = 32'sh0001_0000;
        sp.uv_h = 32'sh0001_0000;
        sp.tex_handle = 16'h5a5a;
        sp.rgba = 32'hff80_4020;
        sp.angle = ang;
        return sp;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            sprite_ch.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (sprite_ch.valid && sprite_ch.ready) begin
                predict_quad(sprite_ch.data);
                sprites_sent <= sprites_sent + 1;
                if (sprite_ch.data.cmd == CMD_ROTATED) rotated_sent <= rotated_sent + 1;
            end
            if (!(sprite_ch.valid && !sprite_ch.ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    sprite_ch.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 3);
                    sprite_ch.valid <= 1'b0;
                end else if (pending_sprites.size() > 0 && !hold_send) begin
                    sprite_ch.data <= pending_sprites.pop_front();
                    sprite_ch.valid <= 1'b1;
                end else begin
                    sprite_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (!i_rst_n) begin
            vertex_ch.ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (vertex_ch.valid && vertex_ch.ready) begin
                vertices_seen <= vertices_seen + 1;
                if (expected_vertices.size() == 0) begin
                    $display("%0t: vertex with none expected, actual %p", $time, vertex_ch.data);
                    errors <= errors + 1;
                end else begin
                    exp_v = expected_vertices.pop_front();
                    if (vertex_ch.data !== exp_v) begin
                        $display("%0t: vertex mismatch, expected %p, actual %p",
                                 $time, exp_v, vertex_ch.data);
                        errors <= errors + 1;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                vertex_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                recv_stall <= $urandom_range(0, 3);
                vertex_ch.ready <= 1'b0;
            end else begin
                vertex_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** sprite_quad_vertex_generator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        t_sprite sp;
        sprite_ch.valid = 1'b0;
        sprite_ch.data = '0;
        vertex_ch.ready = 1'b0;
        pending_sprites.push_back(plain_sprite(CMD_AXIS, 16'h0000));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'h0000));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'sd6434));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'sd12868));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'sd12869));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, -16'sd12868));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, -16'sd12869));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'sd25736));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'h7fff));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'h8000));
        pending_sprites.push_back(plain_sprite(CMD_ROTATED, 16'hffff));
        for (int i = 0; i < 6; i++) begin
            sp = '1;
            sp.cmd = i[0];
            sp.angle = (i < 2) ? 16'h7fff : 16'h8000;
            if (i >= 2) begin
                sp.dest_x = 32'h7fffffff; sp.dest_y = 32'h7fffffff;
                sp.dest_w = 32'h7fffffff; sp.dest_h = 32'h7fffffff;
                sp.uv_x = 32'h7fffffff; sp.uv_y = 32'h7fffffff;
                sp.uv_w = 32'h7fffffff; sp.uv_h = 32'h7fffffff;
            end
            if (i >= 4) begin
                sp.dest_x = 32'h80000000; sp.dest_y = 32'h80000000;
                sp.dest_w = 32'h80000000; sp.dest_h = 32'h80000000;
                sp.uv_x = 32'h80000000; sp.uv_y = 32'h80000000;
                sp.uv_w = 32'h80000000; sp.uv_h = 32'h80000000;
                sp.tex_handle = '0; sp.rgba = '0;
            end
            pending_sprites.push_back(sp);
        end
        sp = plain_sprite(CMD_ROTATED, 16'sd3000);
        sp.dest_w = -32'sd65536;
        sp.dest_h = -32'sd98304;
        pending_sprites.push_back(sp);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_sprites.size() == 0);
        hold_send = 1'b1;
        wait (expected_vertices.size() == 0 && !sprite_ch.valid);
        repeat (3) @(posedge i_clk);
        hold_send = 1'b0;

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM * 3 / 4) begin
                wait (pending_sprites.size() == 0);
                quiet = 1'b1;
            end
            pending_sprites.push_back(random_sprite());
        end

        wait (pending_sprites.size() == 0);
        @(posedge i_clk);
        wait (!sprite_ch.valid && expected_vertices.size() == 0);
        repeat (LATENCY) @(posedge i_clk);

        $display("sent %0d sprites (%0d rotated), checked %0d vertices",
                 sprites_sent, rotated_sent, vertices_seen);
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("** sprite_quad_vertex_generator_core: PASSED **");
        end else begin
            $display("** sprite_quad_vertex_generator_core: FAILED **");
        end
        $finish;
    end
endmodule
